/* sv/rth_pkg.sv */
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies; every other file in sv/ refers to this package by scoped names.
package rth_pkg;

  // Default channel width; the top level takes it as its parameter default.
  localparam int CHANNEL_BITS_DEF = 8;

  // Output field widths.
  localparam int HUE_BITS = 15;
  localparam int OUT_BITS = 8;

  // Hue divider quotient width: the hue quotient never exceeds one sector (3840).
  localparam int HUE_Q_BITS = 12;

  // Hue scale in 1/64 degree.
  localparam logic [HUE_BITS-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_BITS-1:0] HUE_GREEN  = 15'd7680;
  localparam logic [HUE_BITS-1:0] HUE_BLUE   = 15'd15360;
  localparam logic [HUE_BITS-1:0] HUE_TURN   = 15'd23040;

  // Which channel holds the maximum (red wins ties, then green).
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Per-pixel control that rides along the divider pipeline.
  typedef struct packed {
    sector_t sector;
    logic    neg;   // hue fraction is negative (any sector)
    logic    grey;  // max equals min: hue undefined, saturation zero
  } ctl_t;

endpackage

/* sv/rth_front.sv */
// Front end of the converter: channel max/min and sector pick, then delta,
// hue fraction and both divider dividends. Two register stages.
// Depends on rth_pkg.
module rth_front #(
  parameter int CB = rth_pkg::CHANNEL_BITS_DEF,
  parameter int QB = rth_pkg::HUE_Q_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 feed_valid,
  output logic                 feed_ready,
  input  logic [CB-1:0]        red,
  input  logic [CB-1:0]        green,
  input  logic [CB-1:0]        blue,
  output logic                 pass_valid,
  input  logic                 pass_ready,
  output rth_pkg::ctl_t        pass_ctl,
  output logic [CB-1:0]        pass_value,
  output logic [CB-1:0]        pass_sat_den,
  output logic [CB+QB-1:0]     pass_sat_work,
  output logic [CB-1:0]        pass_hue_den,
  output logic [CB+QB-1:0]     pass_hue_work
);

  // Stage A registers
  logic                 a_valid;
  logic                 a_ready;
  logic [CB-1:0]        a_red;
  logic [CB-1:0]        a_green;
  logic [CB-1:0]        a_blue;
  logic [CB-1:0]        a_max;
  logic [CB-1:0]        a_min;
  rth_pkg::sector_t     a_sector;

  logic [CB-1:0]        max_next;
  logic [CB-1:0]        min_next;
  rth_pkg::sector_t     sector_next;

  // Stage B combinational terms
  logic [CB-1:0]        delta;
  logic [CB-1:0]        term_p;
  logic [CB-1:0]        term_q;
  logic                 frac_neg;
  logic [CB-1:0]        frac_mag;
  logic [CB+11:0]       hue_dvd;
  logic [2*CB-1:0]      sat_dvd;
  logic [CB+QB-1:0]     hue_work_next;
  logic [CB+QB-1:0]     sat_work_next;

  always_comb begin
    max_next = red;
    if (green > max_next) max_next = green;
    if (blue > max_next) max_next = blue;
    min_next = red;
    if (green < min_next) min_next = green;
    if (blue < min_next) min_next = blue;
    priority if (red == max_next) begin
      sector_next = rth_pkg::SEC_RED;
    end else if (green == max_next) begin
      sector_next = rth_pkg::SEC_GREEN;
    end else begin
      sector_next = rth_pkg::SEC_BLUE;
    end
  end

  assign feed_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (feed_ready) begin
      a_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && feed_ready) begin
      a_red    <= red;
      a_green  <= green;
      a_blue   <= blue;
      a_max    <= max_next;
      a_min    <= min_next;
      a_sector <= sector_next;
    end
  end

  // Fraction numerator p - q for the chosen sector, as sign and magnitude.
  always_comb begin
    unique case (a_sector)
      rth_pkg::SEC_RED: begin
        term_p = a_green;
        term_q = a_blue;
      end
      rth_pkg::SEC_GREEN: begin
        term_p = a_blue;
        term_q = a_red;
      end
      rth_pkg::SEC_BLUE: begin
        term_p = a_red;
        term_q = a_green;
      end
      default: begin
        term_p = a_green;
        term_q = a_blue;
      end
    endcase
  end

  assign delta    = a_max - a_min;
  assign frac_neg = term_p < term_q;
  assign frac_mag = frac_neg ? (term_q - term_p) : (term_p - term_q);

  // 3840 * mag = mag*4096 - mag*256; FULL * delta = delta*2^CB - delta.
  assign hue_dvd = {frac_mag, 12'd0} - {4'd0, frac_mag, 8'd0};
  assign sat_dvd = {delta, {CB{1'b0}}} - {{CB{1'b0}}, delta};

  assign hue_work_next = (CB+QB)'(hue_dvd);
  assign sat_work_next = (CB+QB)'(sat_dvd);

  assign a_ready = !pass_valid || pass_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_valid <= 1'b0;
    end else if (a_ready) begin
      pass_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      pass_ctl.sector <= a_sector;
      pass_ctl.neg    <= frac_neg;
      pass_ctl.grey   <= (delta == '0);
      pass_value      <= a_max;
      pass_sat_den    <= a_max;
      pass_sat_work   <= sat_work_next;
      pass_hue_den    <= delta;
      pass_hue_work   <= hue_work_next;
    end
  end

endmodule

/* sv/rth_div_step.sv */
// One restoring-division step for both the saturation and hue dividers,
// one quotient bit each, behind one register stage. Depends on rth_pkg.
module rth_div_step #(
  parameter int CB = rth_pkg::CHANNEL_BITS_DEF,
  parameter int QB = rth_pkg::HUE_Q_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 feed_valid,
  output logic                 feed_ready,
  input  rth_pkg::ctl_t        feed_ctl,
  input  logic [CB-1:0]        feed_value,
  input  logic [CB-1:0]        feed_sat_den,
  input  logic [CB+QB-1:0]     feed_sat_work,
  input  logic [CB-1:0]        feed_hue_den,
  input  logic [CB+QB-1:0]     feed_hue_work,
  output logic                 pass_valid,
  input  logic                 pass_ready,
  output rth_pkg::ctl_t        pass_ctl,
  output logic [CB-1:0]        pass_value,
  output logic [CB-1:0]        pass_sat_den,
  output logic [CB+QB-1:0]     pass_sat_work,
  output logic [CB-1:0]        pass_hue_den,
  output logic [CB+QB-1:0]     pass_hue_work
);

  // Work word is {remainder, dividend bits left / quotient bits so far}.
  function automatic logic [CB+QB-1:0] div_step(input logic [CB+QB-1:0] work,
                                                input logic [CB-1:0] den);
    logic [CB:0]   trial;
    logic [CB:0]   diff;
    logic [CB-1:0] rem;
    logic          qbit;
    trial = work[CB+QB-1:QB-1];
    diff  = trial - {1'b0, den};
    qbit  = trial >= {1'b0, den};
    rem   = qbit ? diff[CB-1:0] : trial[CB-1:0];
    return {rem, work[QB-2:0], qbit};
  endfunction

  assign feed_ready = !pass_valid || pass_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_valid <= 1'b0;
    end else if (feed_ready) begin
      pass_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && feed_ready) begin
      pass_ctl      <= feed_ctl;
      pass_value    <= feed_value;
      pass_sat_den  <= feed_sat_den;
      pass_sat_work <= div_step(feed_sat_work, feed_sat_den);
      pass_hue_den  <= feed_hue_den;
      pass_hue_work <= div_step(feed_hue_work, feed_hue_den);
    end
  end

endmodule

/* sv/rth_back.sv */
// Output stage: turns the hue quotient into a floored, wrapped angle and
// drives the result word registers. Depends on rth_pkg.
module rth_back #(
  parameter int CB = rth_pkg::CHANNEL_BITS_DEF,
  parameter int QB = rth_pkg::HUE_Q_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          feed_valid,
  output logic                          feed_ready,
  input  rth_pkg::ctl_t                 feed_ctl,
  input  logic [CB-1:0]                 feed_value,
  input  logic [CB+QB-1:0]              feed_sat_work,
  input  logic [CB+QB-1:0]              feed_hue_work,
  output logic                          pass_valid,
  input  logic                          pass_ready,
  output logic [rth_pkg::HUE_BITS-1:0]  hue,
  output logic                          defined,
  output logic [rth_pkg::OUT_BITS-1:0]  saturation,
  output logic [rth_pkg::OUT_BITS-1:0]  value
);

  localparam int HB = rth_pkg::HUE_BITS;
  localparam int OB = rth_pkg::OUT_BITS;

  logic [QB+HB-1:0]  hue_q_ext;
  logic [HB-1:0]     hue_q;
  logic              hue_rem_nz;
  logic [HB-1:0]     hue_ceil;
  logic [HB-1:0]     hue_base;
  logic [HB-1:0]     hue_next;
  logic [CB+OB-1:0]  sat_ext;
  logic [CB+OB-1:0]  value_ext;

  assign hue_q_ext  = {{HB{1'b0}}, feed_hue_work[QB-1:0]};
  assign hue_q      = hue_q_ext[HB-1:0];
  assign hue_rem_nz = |feed_hue_work[CB+QB-1:QB];
  assign hue_ceil   = hue_q + {{(HB-1){1'b0}}, hue_rem_nz};

  always_comb begin
    unique case (feed_ctl.sector)
      rth_pkg::SEC_RED:   hue_base = '0;
      rth_pkg::SEC_GREEN: hue_base = rth_pkg::HUE_GREEN;
      rth_pkg::SEC_BLUE:  hue_base = rth_pkg::HUE_BLUE;
      default:            hue_base = '0;
    endcase
  end

  // Negative fraction: floor is the sector base minus the ceiling; the red
  // sector wraps down from a full turn instead of from zero.
  always_comb begin
    priority if (feed_ctl.grey) begin
      hue_next = '0;
    end else if (feed_ctl.neg) begin
      hue_next = ((feed_ctl.sector == rth_pkg::SEC_RED) ? rth_pkg::HUE_TURN : hue_base)
                 - hue_ceil;
    end else begin
      hue_next = hue_base + hue_q;
    end
  end

  assign sat_ext   = {{OB{1'b0}}, feed_sat_work[CB-1:0]};
  assign value_ext = {{OB{1'b0}}, feed_value};

  assign feed_ready = !pass_valid || pass_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_valid <= 1'b0;
    end else if (feed_ready) begin
      pass_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && feed_ready) begin
      hue        <= hue_next;
      defined    <= !feed_ctl.grey;
      saturation <= feed_ctl.grey ? '0 : sat_ext[OB-1:0];
      value      <= value_ext[OB-1:0];
    end
  end

endmodule

/* sv/rgb_to_hsv.sv */
// RGB to HSV pixel converter, top level. Uses rth_pkg, rth_front, rth_div_step, rth_back.
// Pipeline: two front stages, QB = max(12, CHANNEL_BITS) divider steps, one output stage.
// Throughput: one pixel per clock unless hsv_ready stalls the output stage;
//   each divider step resolves one quotient bit per stage.
// A stalled stage holds its word while emptier stages behind it keep filling.
// Reset (rst, synchronous) clears every stage valid bit; data registers are not reset.
module rgb_to_hsv #(
  parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [CHANNEL_BITS-1:0]       red_in,
  input  logic [CHANNEL_BITS-1:0]       green_in,
  input  logic [CHANNEL_BITS-1:0]       blue_in,
  output logic                          hsv_valid,
  input  logic                          hsv_ready,
  output logic [rth_pkg::HUE_BITS-1:0]  hue_out,
  output logic                          hue_defined,
  output logic [rth_pkg::OUT_BITS-1:0]  saturation_out,
  output logic [rth_pkg::OUT_BITS-1:0]  value_out
);

  localparam int CB = CHANNEL_BITS;
  // Both dividers run the same number of steps: enough quotient bits for
  // a full sector of hue (3840) and for full-scale saturation.
  localparam int QB = (CB > rth_pkg::HUE_Q_BITS) ? CB : rth_pkg::HUE_Q_BITS;

  // Divider pipeline taps: index 0 is the front end output, index QB the
  // last step output feeding the output stage.
  logic                 st_valid    [QB+1];
  logic                 st_ready    [QB+1];
  rth_pkg::ctl_t        st_ctl      [QB+1];
  logic [CB-1:0]        st_value    [QB+1];
  logic [CB-1:0]        st_sat_den  [QB+1];
  logic [CB+QB-1:0]     st_sat_work [QB+1];
  logic [CB-1:0]        st_hue_den  [QB+1];
  logic [CB+QB-1:0]     st_hue_work [QB+1];

  // Max/min, sector, delta and dividends.
  rth_front #(
    .CB (CB),
    .QB (QB)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .feed_valid    (pixel_valid),
    .feed_ready    (pixel_ready),
    .red           (red_in),
    .green         (green_in),
    .blue          (blue_in),
    .pass_valid    (st_valid[0]),
    .pass_ready    (st_ready[0]),
    .pass_ctl      (st_ctl[0]),
    .pass_value    (st_value[0]),
    .pass_sat_den  (st_sat_den[0]),
    .pass_sat_work (st_sat_work[0]),
    .pass_hue_den  (st_hue_den[0]),
    .pass_hue_work (st_hue_work[0])
  );

  // One quotient bit per stage for saturation and hue side by side.
  for (genvar k = 0; k < QB; k++) begin : g_step
    rth_div_step #(
      .CB (CB),
      .QB (QB)
    ) u_step (
      .clk           (clk),
      .rst           (rst),
      .feed_valid    (st_valid[k]),
      .feed_ready    (st_ready[k]),
      .feed_ctl      (st_ctl[k]),
      .feed_value    (st_value[k]),
      .feed_sat_den  (st_sat_den[k]),
      .feed_sat_work (st_sat_work[k]),
      .feed_hue_den  (st_hue_den[k]),
      .feed_hue_work (st_hue_work[k]),
      .pass_valid    (st_valid[k+1]),
      .pass_ready    (st_ready[k+1]),
      .pass_ctl      (st_ctl[k+1]),
      .pass_value    (st_value[k+1]),
      .pass_sat_den  (st_sat_den[k+1]),
      .pass_sat_work (st_sat_work[k+1]),
      .pass_hue_den  (st_hue_den[k+1]),
      .pass_hue_work (st_hue_work[k+1])
    );
  end

  // Floor, sector offset and wrap of hue; drive the result word.
  rth_back #(
    .CB (CB),
    .QB (QB)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .feed_valid    (st_valid[QB]),
    .feed_ready    (st_ready[QB]),
    .feed_ctl      (st_ctl[QB]),
    .feed_value    (st_value[QB]),
    .feed_sat_work (st_sat_work[QB]),
    .feed_hue_work (st_hue_work[QB]),
    .pass_valid    (hsv_valid),
    .pass_ready    (hsv_ready),
    .hue           (hue_out),
    .defined       (hue_defined),
    .saturation    (saturation_out),
    .value         (value_out)
  );

  // Grey pixels carry zero hue and zero saturation.
  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !hue_defined |-> hue_out == '0 && saturation_out == '0)
    else $error("grey pixel with nonzero hue or saturation");

  // Hue always lands inside one turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hue_out < rth_pkg::HUE_TURN)
    else $error("hue outside one turn");

  // No result word right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !hsv_valid)
    else $error("result valid right after reset");

endmodule
